FILE: src/sfc_pkg.sv
package sfc_pkg;

    localparam int FRAC_COEF  = 14;
    localparam int FRAC_GAIN  = 16;
    localparam int GAIN_W     = 17;
    localparam int CAL_W      = 11;
    localparam int OP_W       = 1;
    localparam int IDX_W      = 6;
    localparam int AXIS_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;
    localparam logic [CAL_W-1:0]  CAL_MAX   = 11'd1024;
    localparam logic [CAL_W-1:0]  CAL_RESET = 11'd200;

    localparam logic [OP_W-1:0] OP_SAMPLE = 1'b0;
    localparam logic [OP_W-1:0] OP_LOAD   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL  = 1'b1;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,     // write one coefficient
        CMD_CAPTURE,  // latch sample, accumulate offsets if calibrating
        CMD_DIV,      // one step of offset division
        CMD_DIFF,     // form offset-removed differences
        CMD_MAC,      // one matrix product term
        CMD_FILT_MUL, // filter multiply
        CMD_FILT_UPD  // filter update and present result
    } cmd_e_t;

    typedef struct packed {
        cmd_e_t         cmd;
        logic [2:0]     row;
        logic [2:0]     col;
        logic           first;
        logic           present;
    } ctl_t;

    typedef struct packed {
        logic calibrating;
        logic cal_done_now;
        logic div_done;
        logic out_busy;
    } sts_t;

endpackage

FILE: src/sfc_ctrl.sv
module sfc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_op,
    output logic          in_stall,
    input  sfc_pkg::sts_t sts,
    output sfc_pkg::ctl_t ctl
);
    import sfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_DIFF, S_MAC, S_FMUL, S_FUPD, S_OUT
    } state_t;

    state_t     state_reg;
    logic [2:0] row_reg;
    logic [2:0] col_reg;
    logic [2:0] axes_m1;

    assign axes_m1 = 3'd5;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctl.cmd = CMD_NONE;
        ctl.row = row_reg;
        ctl.col = col_reg;
        ctl.first = (col_reg == 3'd0);
        ctl.present = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    ctl.cmd = (in_op == OP_LOAD) ? CMD_LOAD : CMD_CAPTURE;
            end
            S_DIV:  ctl.cmd = CMD_DIV;
            S_DIFF: ctl.cmd = CMD_DIFF;
            S_MAC:  ctl.cmd = CMD_MAC;
            S_FMUL: ctl.cmd = CMD_FILT_MUL;
            S_FUPD:
            begin
                if (!sts.out_busy)
                begin
                    ctl.cmd = CMD_FILT_UPD;
                    ctl.present = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                    ctl.present = 1'b1;
            end
            default: ctl.cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                    if (in_valid && in_op == OP_SAMPLE)
                    begin
                        if (!sts.calibrating)
                            state_reg <= S_DIFF;
                        else if (sts.cal_done_now)
                            state_reg <= S_DIV;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (sts.div_done)
                        state_reg <= S_OUT;
                end
                S_DIFF: state_reg <= S_MAC;
                S_MAC:
                begin
                    if (col_reg == axes_m1)
                    begin
                        col_reg   <= '0;
                        state_reg <= S_FMUL;
                    end
                    else
                        col_reg <= col_reg + 3'd1;
                end
                S_FMUL: state_reg <= S_FUPD;
                S_FUPD:
                begin
                    if (!sts.out_busy)
                    begin
                        if (row_reg == axes_m1)
                            state_reg <= S_IDLE;
                        else
                        begin
                            row_reg   <= row_reg + 3'd1;
                            state_reg <= S_MAC;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!sts.out_busy)
                    begin
                        if (row_reg == axes_m1)
                            state_reg <= S_IDLE;
                        else
                            row_reg <= row_reg + 3'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= axes_m1) else $error("row out of range");
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= axes_m1) else $error("column out of range");
    a_present_state: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.present |-> (state_reg == S_FUPD || state_reg == S_OUT))
        else $error("result outside output states");
`endif
endmodule

FILE: src/sfc_datapath.sv
module sfc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfc_pkg::ctl_t               ctl,
    output sfc_pkg::sts_t               sts,
    input  logic [sfc_pkg::CFG_DATA_W-1:0] gain_cfg,
    input  logic [sfc_pkg::CAL_W-1:0]   cal_cfg,
    input  logic [sfc_pkg::IDX_W-1:0]   coef_index,
    input  logic signed [17:0]          coef_value,
    input  logic signed [31:0]          sample_in [6],
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sfc_pkg::AXIS_W-1:0]  axis,
    output logic signed [31:0]          corrected_value,
    output logic signed [31:0]          filtered_value,
    output logic signed [31:0]          rate_value,
    output logic                        calibrated,
    output logic                        last
);
    import sfc_pkg::*;

    localparam logic signed [63:0] SMAX = 64'sd2147483647;
    localparam logic signed [63:0] SMIN = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > SMAX)
            return 32'sh7fffffff;
        else if (v < SMIN)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic signed [17:0] coef_mem [36];
    logic               coef_wr_reg [36];
    logic signed [31:0] raw_reg  [6];
    logic signed [31:0] diff_reg [6];
    logic signed [41:0] osum_reg [6];
    logic signed [41:0] off_reg  [6];
    logic signed [31:0] filt_reg [6];
    logic signed [31:0] corr_reg [6];
    logic [CAL_W-1:0]   count_reg;
    logic               done_reg;
    logic [CAL_W-1:0]   n_eff;
    logic [CAL_W-1:0]   n_hold_reg;

    // offset divider: restoring, one quotient bit per cycle, all axes in parallel
    logic [41:0]        drem_reg [6];
    logic [41:0]        dquo_reg [6];
    logic [5:0]         dstep_reg;
    logic               dinit_reg;

    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] fprod_reg;
    logic signed [31:0] filt_upd;

    logic [CAL_W-1:0]   count_inc;
    logic signed [17:0] coef_rd;
    logic signed [17:0] coef_q_reg;
    logic               coef_hit_reg;
    logic               coef_diag_reg;
    logic [2:0]         rd_row;
    logic [2:0]         rd_col;
    logic [5:0]         rd_addr;
    logic [GAIN_W-1:0]  gain_eff;

    assign n_eff = (cal_cfg == '0) ? CAL_W'(1) : ((cal_cfg > CAL_MAX) ? CAL_MAX : cal_cfg);
    assign gain_eff = (gain_cfg > GAIN_ONE) ? GAIN_ONE : gain_cfg;
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + CAL_W'(1);

    // address of the coefficient needed by the next product term
    always_comb
    begin
        rd_row = ctl.row;
        rd_col = ctl.col;
        if (ctl.cmd == CMD_MAC)
        begin
            if (ctl.col == 3'd5)
            begin
                rd_row = ctl.row + 3'd1;
                rd_col = 3'd0;
            end
            else
                rd_col = ctl.col + 3'd1;
        end
    end

    assign rd_addr = {3'd0, rd_row} * 6'd6 + {3'd0, rd_col};
    assign coef_rd = coef_hit_reg ? coef_q_reg
                   : (coef_diag_reg ? 18'sd16384 : 18'sd0);
    assign filt_upd = sat32(64'(filt_reg[ctl.row])
                            + ((fprod_reg + 64'sd32768) >>> FRAC_GAIN));

    assign sts.calibrating  = !done_reg;
    assign sts.cal_done_now = (count_inc >= n_eff);
    assign sts.div_done     = !dinit_reg && (dstep_reg == 6'd42);
    assign sts.out_busy     = out_valid && out_stall;

    always_ff @(posedge clk)
    begin
        if (ctl.cmd == CMD_LOAD && coef_index < 6'd36)
            coef_mem[coef_index] <= coef_value;
        // fetch one term ahead
        if ((ctl.cmd == CMD_DIFF || ctl.cmd == CMD_MAC) && rd_addr < 6'd36)
        begin
            coef_q_reg    <= coef_mem[rd_addr];
            coef_hit_reg  <= coef_wr_reg[rd_addr];
            coef_diag_reg <= (rd_row == rd_col);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 36; i++)
                coef_wr_reg[i] <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                osum_reg[i] <= '0;
                off_reg[i]  <= '0;
                filt_reg[i] <= '0;
            end
            count_reg <= '0;
            done_reg  <= 1'b0;
            dstep_reg <= '0;
            dinit_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (ctl.present)
                out_valid <= 1'b1;
            else if (out_valid && !out_stall)
                out_valid <= 1'b0;
            if (ctl.cmd == CMD_LOAD && coef_index < 6'd36)
                coef_wr_reg[coef_index] <= 1'b1;
            if (ctl.cmd == CMD_CAPTURE && !done_reg)
            begin
                for (int i = 0; i < 6; i++)
                    osum_reg[i] <= osum_reg[i] + 42'(sample_in[i]);
                count_reg <= count_inc;
                if (count_inc >= n_eff)
                begin
                    dinit_reg <= 1'b1;
                    dstep_reg <= '0;
                end
            end
            if (ctl.cmd == CMD_DIV)
            begin
                if (dinit_reg)
                    dinit_reg <= 1'b0;
                else if (dstep_reg != 6'd42)
                    dstep_reg <= dstep_reg + 6'd1;
                if (!dinit_reg && dstep_reg == 6'd42)
                begin
                    for (int i = 0; i < 6; i++)
                        off_reg[i] <= osum_reg[i][41]
                            ? -$signed(dquo_reg[i]) : $signed(dquo_reg[i]);
                    done_reg <= 1'b1;
                end
            end
            if (ctl.cmd == CMD_FILT_UPD)
                filt_reg[ctl.row] <= filt_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmd == CMD_CAPTURE)
        begin
            for (int i = 0; i < 6; i++)
            begin
                raw_reg[i]  <= sample_in[i];
                corr_reg[i] <= sample_in[i];
            end
            n_hold_reg <= n_eff;
        end
        if (ctl.cmd == CMD_DIV)
        begin
            if (dinit_reg)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    dquo_reg[i] <= osum_reg[i][41] ? 42'(-osum_reg[i]) : osum_reg[i];
                    drem_reg[i] <= '0;
                end
            end
            else if (dstep_reg != 6'd42)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    logic [42:0] trial;
                    trial = {drem_reg[i], dquo_reg[i][41]} - {32'd0, n_hold_reg};
                    if (!trial[42])
                    begin
                        drem_reg[i] <= trial[41:0];
                        dquo_reg[i] <= {dquo_reg[i][40:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[i] <= {drem_reg[i][40:0], dquo_reg[i][41]};
                        dquo_reg[i] <= {dquo_reg[i][40:0], 1'b0};
                    end
                end
            end
            else
            begin
                for (int i = 0; i < 6; i++)
                    corr_reg[i] <= sat32(64'(raw_reg[i]) - (osum_reg[i][41]
                        ? -64'(dquo_reg[i]) : 64'(dquo_reg[i])));
            end
        end
        if (ctl.cmd == CMD_DIFF)
        begin
            for (int i = 0; i < 6; i++)
                diff_reg[i] <= sat32(64'(raw_reg[i]) - 64'(off_reg[i]));
        end
        // multiply one term, accumulate the previous one
        if (ctl.cmd == CMD_MAC)
        begin
            prod_reg <= 64'(coef_rd) * 64'(diff_reg[ctl.col]);
            if (ctl.first)
                acc_reg <= '0;
            else
                acc_reg <= acc_reg + prod_reg;
        end
        if (ctl.cmd == CMD_FILT_MUL)
        begin
            logic signed [63:0] fin;
            logic signed [31:0] tv;
            fin = acc_reg + prod_reg + 64'sd8192;
            tv = sat32(fin >>> FRAC_COEF);
            corr_reg[ctl.row] <= tv;
            fprod_reg <= $signed({1'b0, gain_eff}) * (64'(tv) - 64'(filt_reg[ctl.row]));
        end
        if (ctl.present)
        begin
            axis            <= ctl.row;
            corrected_value <= corr_reg[ctl.row];
            filtered_value  <= (ctl.cmd == CMD_FILT_UPD) ? filt_upd : filt_reg[ctl.row];
            rate_value      <= (ctl.cmd == CMD_FILT_UPD)
                ? sat32(64'(filt_upd) - 64'(filt_reg[ctl.row])) : 32'sd0;
            calibrated      <= done_reg;
            last            <= (ctl.row == 3'd5);
        end
    end

`ifndef ASSERT_OFF
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cmd == CMD_MAC) |-> done_reg) else $error("product before calibration");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sts.out_busy |-> !ctl.present) else $error("overwrite of stalled result");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> $stable(off_reg[0])) else $error("offset moved after calibration");
`endif
endmodule

FILE: src/six_axis_force_conditioner_unit.sv
// Flow: a calibrating sample goes straight to its results; the sample that completes
//   calibration first runs the 42-step offset division; a calibrated sample runs the products.
// Each sample yields six results, one per axis; a calibrated sample runs six 6-term products
//   on one shared multiplier plus filter multiply and update per axis. No new sample or
//   load is accepted until the last result has been presented; output stalls hold the unit.
// Reset: asynchronous, active low; identity matrix, zero offsets and filter state.
module six_axis_force_conditioner_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [5:0]                        coef_index,
    input  logic signed [17:0]                coef_value,
    input  logic signed [31:0]                force_x,
    input  logic signed [31:0]                force_y,
    input  logic signed [31:0]                force_z,
    input  logic signed [31:0]                torque_x,
    input  logic signed [31:0]                torque_y,
    input  logic signed [31:0]                torque_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        axis,
    output logic signed [31:0]                corrected_value,
    output logic signed [31:0]                filtered_value,
    output logic signed [31:0]                rate_value,
    output logic                              calibrated,
    output logic                              last
);
    import sfc_pkg::*;

    logic [CFG_DATA_W-1:0] gain_reg;
    logic [CAL_W-1:0]      cal_reg;
    logic                  accept;
    logic signed [31:0]    sample_in [6];
    ctl_t                  ctl;
    sts_t                  sts;
    logic                  ctrl_stall;

    assign sample_in[0] = force_x;
    assign sample_in[1] = force_y;
    assign sample_in[2] = force_z;
    assign sample_in[3] = torque_x;
    assign sample_in[4] = torque_y;
    assign sample_in[5] = torque_z;
    assign in_stall = ctrl_stall;
    assign accept = in_valid && !ctrl_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_ONE;
            cal_reg  <= CAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN: gain_reg <= cfg_data;
                REG_CAL:  cal_reg  <= cfg_data[CAL_W-1:0];
                default:  gain_reg <= gain_reg;
            endcase
        end
    end

    sfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_op    (operation),
        .in_stall (ctrl_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    sfc_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .gain_cfg        (gain_reg),
        .cal_cfg         (cal_reg),
        .coef_index      (coef_index),
        .coef_value      (coef_value),
        .sample_in       (sample_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .axis            (axis),
        .corrected_value (corrected_value),
        .filtered_value  (filtered_value),
        .rate_value      (rate_value),
        .calibrated      (calibrated),
        .last            (last)
    );
endmodule
